>>> hdl/smtp_message_classifier_defines.svh
// Assertion macros used by the classifier tracker.
`ifndef SMTP_MESSAGE_CLASSIFIER_DEFINES_SVH
`define SMTP_MESSAGE_CLASSIFIER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define SMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/smc_pkg.sv
// Types, constants and keyword table of the SMTP message classifier.
package smc_pkg;

	localparam int NUM_KW     = 17;
	localparam int KW_MAX_LEN = 8;

	typedef logic [7:0]        byte_t;
	typedef logic [3:0]        pos_t;
	typedef logic [NUM_KW-1:0] kw_mask_t;
	typedef logic [4:0]        kw_idx_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_COMMAND = 2'd2
	} kind_t;

	// Only the first nine bytes of a payload are inspected.
	localparam pos_t WINDOW_POS = 4'd9;
	// Position of the separator after the three reply digits.
	localparam pos_t REPLY_POS  = 4'd3;

	localparam byte_t CH_NUL     = 8'h00;
	localparam byte_t CH_CR      = 8'h0D;
	localparam byte_t CH_SPACE   = 8'h20;
	localparam byte_t CH_HYPHEN  = 8'h2D;
	localparam byte_t CH_ZERO    = 8'h30;
	localparam byte_t CH_NINE    = 8'h39;
	localparam byte_t CH_LOWER_A = 8'h61;
	localparam byte_t CH_LOWER_Z = 8'h7A;
	localparam byte_t CASE_BIT   = 8'h20;

	localparam byte_t KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
		'{"H", "E", "L", "O", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"E", "H", "L", "O", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"M", "A", "I", "L", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"R", "C", "P", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"D", "A", "T", "A", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"R", "S", "E", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"N", "O", "O", "P", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"Q", "U", "I", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"V", "R", "F", "Y", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"E", "X", "P", "N", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"H", "E", "L", "P", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"S", "E", "N", "D", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"S", "O", "M", "L", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"S", "A", "M", "L", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"T", "U", "R", "N", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"A", "U", "T", "H", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"S", "T", "A", "R", "T", "T", "L", "S"}
	};

	localparam pos_t KW_LEN [NUM_KW] = '{
		4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
		4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd8
	};

	typedef struct packed {
		logic    is_smtp;
		kind_t   match_kind;
		kw_idx_t command_code;
	} verdict_t;

	typedef struct packed {
		pos_t     pos;
		kw_mask_t cand;
		logic     digits_ok;
		logic     reply;
		logic     cmd;
		kw_idx_t  code;
	} track_t;

	localparam track_t TRACK_RESET = '{
		pos:       '0,
		cand:      '1,
		digits_ok: 1'b1,
		reply:     1'b0,
		cmd:       1'b0,
		code:      '0
	};

endpackage

>>> hdl/smc_in_if.sv
// Payload byte channel of the classifier.
interface smc_in_if import smc_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t payload_byte;
	logic  end_of_payload;

	modport source (output valid, payload_byte, end_of_payload, input ready);
	modport sink   (input valid, payload_byte, end_of_payload, output ready);
endinterface

>>> hdl/smc_out_if.sv
// Verdict channel of the classifier.
interface smc_out_if import smc_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    is_smtp;
	kind_t   match_kind;
	kw_idx_t command_code;

	modport source (output valid, is_smtp, match_kind, command_code, input ready);
	modport sink   (input valid, is_smtp, match_kind, command_code, output ready);
endinterface

>>> hdl/smtp_message_classifier.sv
// Top level of the SMTP message classifier: input register, tracker, verdict register.
//
//   channel   dir   carries                                   item per
//   bytes     in    payload_byte, end_of_payload              payload byte
//   verdict   out   is_smtp, match_kind, command_code         payload (on its last byte)
//
// One byte is taken every cycle unless a held verdict stalls a last byte; a verdict is
// registered in the verdict register after the last byte leaves the input register. The rate
// is set by the single pass through the tracker between the input register and the tracker state / verdict register.
// Reset clears the match state and the valid flags of the input and verdict registers.
// A held verdict stalls only a last byte waiting in the input register; other bytes flow.
module smtp_message_classifier import smc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	smc_in_if.sink     bytes,
	smc_out_if.source  verdict
);

	logic     valid_s1;
	byte_t    data_s1;
	logic     last_s1;
	logic     step;
	verdict_t step_verdict;
	logic     out_valid_q;
	verdict_t verdict_q;

	// a last byte needs the verdict register free or draining
	assign step        = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign bytes.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1 <= bytes.payload_byte;
			last_s1 <= bytes.end_of_payload;
		end
	end

	smc_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (data_s1),
		.last   (last_s1),
		.result (step_verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			verdict_q <= step_verdict;
		end
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.is_smtp      = verdict_q.is_smtp;
	assign verdict.match_kind   = verdict_q.match_kind;
	assign verdict.command_code = verdict_q.command_code;

endmodule

>>> hdl/smc_tracker.sv
// Per-payload match state and the byte-by-byte keyword and reply checks.
`include "smtp_message_classifier_defines.svh"

module smc_tracker import smc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  byte_t    data,
	input  logic     last,
	output verdict_t result
);

	track_t track_q;
	track_t track_d;
	track_t cur;

	always_comb begin
		byte_t    up;
		logic     is_digit;
		logic     sep_cmd;
		kw_mask_t hit;
		kw_idx_t  first_idx;
		pos_t     pos1;

		cur       = track_q;
		hit       = '0;
		first_idx = '0;
		up        = data;
		is_digit  = (data >= CH_ZERO) && (data <= CH_NINE);
		sep_cmd   = (data == CH_SPACE) || (data == CH_CR);
		pos1      = track_q.pos + 4'd1;

		if ((data >= CH_LOWER_A) && (data <= CH_LOWER_Z)) begin
			up = data & ~CASE_BIT;
		end

		if (track_q.pos < WINDOW_POS) begin
			if (track_q.pos < REPLY_POS) begin
				if (!is_digit) begin
					cur.digits_ok = 1'b0;
				end
			end else if (track_q.pos == REPLY_POS) begin
				if (track_q.digits_ok && ((data == CH_SPACE) || (data == CH_HYPHEN))) begin
					cur.reply = 1'b1;
				end
			end

			for (int k = 0; k < NUM_KW; k++) begin
				if (track_q.pos < KW_LEN[k]) begin
					if (up != KW_TEXT[k][track_q.pos[2:0]]) begin
						cur.cand[k] = 1'b0;
					end
				end else if (track_q.pos == KW_LEN[k]) begin
					hit[k] = track_q.cand[k] && sep_cmd;
				end
			end

			// payload ends right after a whole keyword
			if (last) begin
				for (int k = 0; k < NUM_KW; k++) begin
					if (cur.cand[k] && (pos1 == KW_LEN[k])) begin
						hit[k] = 1'b1;
					end
				end
			end

			for (int k = NUM_KW - 1; k >= 0; k--) begin
				if (hit[k]) begin
					first_idx = kw_idx_t'(k);
				end
			end

			if (!track_q.cmd && (|hit)) begin
				cur.cmd  = 1'b1;
				cur.code = first_idx;
			end

			cur.pos = pos1;
		end
	end

	always_comb begin
		if (cur.reply) begin
			result = '{is_smtp: 1'b1, match_kind: KIND_REPLY, command_code: '0};
		end else if (cur.cmd) begin
			result = '{is_smtp: 1'b1, match_kind: KIND_COMMAND, command_code: cur.code};
		end else begin
			result = '{is_smtp: 1'b0, match_kind: KIND_NONE, command_code: '0};
		end
	end

	always_comb begin
		track_d = track_q;
		if (step) begin
			track_d = last ? TRACK_RESET : cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= TRACK_RESET;
		end else begin
			track_q <= track_d;
		end
	end

	`SMC_ASSERT(pos_in_window, track_q.pos <= WINDOW_POS, "byte position past window")
	`SMC_ASSERT(kinds_exclusive, !(track_q.reply && track_q.cmd), "reply and command both found")
	`SMC_ASSERT(code_needs_command, !track_q.cmd |-> (track_q.code == '0), "stray command code")
	`SMC_ASSERT_NEXT(clear_after_last, step && last, track_q == TRACK_RESET, "state not cleared")
	`SMC_ASSERT_NEXT(hold_without_step, !step, $stable(track_q), "state moved without a byte")

endmodule
